/* hdl/vcsp_pkg.sv */
// ----------------------------------------------------------------------------
// vcsp_pkg: shared types and constants of the voxel column span projector
// Holds the controller states, the command and status groups between the
// controller and the datapath, and the fixed field widths.
// ----------------------------------------------------------------------------
package vcsp_pkg;

	// Field widths fixed by the stream formats
	localparam int COLUMN_W  = 9;
	localparam int DEPTH_W   = 10;
	localparam int TERRAIN_W = 8;
	localparam int COLOR_W   = 16;
	localparam int ROW_W     = 8;
	localparam int TOP_W     = 9;
	localparam int CAM_W     = 10;
	localparam int HOR_W     = 12;
	localparam int SCALE_W   = 8;

	// Arithmetic widths
	localparam int PROD_A_W  = 21;  // (cam - terrain) * scale, signed
	localparam int PROD_B_W  = 23;  // horizon_half * depth, signed
	localparam int NUM_W     = 24;  // full numerator, signed
	localparam int QUO_W     = 23;  // magnitude bits of a non-negative numerator
	localparam int DEN_W     = 11;  // 2 * depth

	// Divider length, one quotient bit a step
	localparam int DIV_STEPS = QUO_W;
	localparam int CNT_W     = 5;

	// Stream widths
	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 48;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_HEIGHT    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HORIZON_HALF     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PROJECTION_SCALE = 2'd2;
	localparam int CFG_DATA_W = HOR_W;

	// Configuration reset values
	localparam logic [CAM_W-1:0]   CAM_RESET   = 10'd70;
	localparam logic [HOR_W-1:0]   HOR_RESET   = 12'd120;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 8'd70;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SUM,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic load_in;   // capture an input beat
		logic mul;       // form both partial products
		logic sum;       // form numerator, load divider
		logic div_step;  // one restoring divide step
		logic finish;    // judge projection, load output register
	} cmd_t;

	typedef struct packed {
		logic out_free;  // output register empty or draining this cycle
	} sts_t;

endpackage

/* hdl/vcsp_ctrl.sv */
// ----------------------------------------------------------------------------
// vcsp_ctrl: sequencing controller of the span projector
// Walks one sample through capture, multiply, sum, divide and finish.
// ----------------------------------------------------------------------------
module vcsp_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  vcsp_pkg::sts_t sts,
	output vcsp_pkg::cmd_t cmd
);

	vcsp_pkg::state_t state_q, state_nxt;
	logic [vcsp_pkg::CNT_W-1:0] cnt_q;
	logic div_last;

	assign div_last = (cnt_q == vcsp_pkg::CNT_W'(vcsp_pkg::DIV_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vcsp_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == vcsp_pkg::ST_DIV)
				cnt_q <= cnt_q + 1'b1;
			else
				cnt_q <= '0;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			vcsp_pkg::ST_IDLE: if (in_valid) state_nxt = vcsp_pkg::ST_MUL;
			vcsp_pkg::ST_MUL:  state_nxt = vcsp_pkg::ST_SUM;
			vcsp_pkg::ST_SUM:  state_nxt = vcsp_pkg::ST_DIV;
			vcsp_pkg::ST_DIV:  if (div_last) state_nxt = vcsp_pkg::ST_FIN;
			vcsp_pkg::ST_FIN:  if (sts.out_free) state_nxt = vcsp_pkg::ST_IDLE;
			default:           state_nxt = vcsp_pkg::ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			vcsp_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
			end
			vcsp_pkg::ST_MUL:  cmd.mul      = 1'b1;
			vcsp_pkg::ST_SUM:  cmd.sum      = 1'b1;
			vcsp_pkg::ST_DIV:  cmd.div_step = 1'b1;
			vcsp_pkg::ST_FIN:  cmd.finish   = sts.out_free;
			default: ;
		endcase
	end

	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> sts.out_free)
		else $error("finish issued while output register is held");

	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == vcsp_pkg::ST_SUM) |=> (state_q == vcsp_pkg::ST_DIV) && (cnt_q == '0))
		else $error("divide did not start with a cleared step count");

endmodule

/* hdl/vcsp_dpath.sv */
// ----------------------------------------------------------------------------
// vcsp_dpath: datapath of the span projector
// Config registers, input capture, products, restoring divider, topmost row
// and output register.
// ----------------------------------------------------------------------------
module vcsp_dpath #(
	parameter int SCREEN_ROWS = 240
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [vcsp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [vcsp_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [vcsp_pkg::COLUMN_W-1:0]     column,
	input  logic [vcsp_pkg::DEPTH_W-1:0]      depth,
	input  logic [vcsp_pkg::TERRAIN_W-1:0]    terrain_height,
	input  logic [vcsp_pkg::COLOR_W-1:0]      texel_color,
	input  logic                              first_in_column,
	input  vcsp_pkg::cmd_t                    cmd,
	output vcsp_pkg::sts_t                    sts,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              draw,
	output logic [vcsp_pkg::COLUMN_W-1:0]     span_column,
	output logic [vcsp_pkg::ROW_W-1:0]        span_top,
	output logic [vcsp_pkg::ROW_W-1:0]        span_bottom,
	output logic [vcsp_pkg::COLOR_W-1:0]      span_color
);

	localparam logic [vcsp_pkg::TOP_W-1:0] ROWS_INIT = vcsp_pkg::TOP_W'(SCREEN_ROWS);

	// Configuration
	logic        [vcsp_pkg::CAM_W-1:0]    cam_q;
	logic signed [vcsp_pkg::HOR_W-1:0]    hor_q;
	logic        [vcsp_pkg::SCALE_W-1:0]  scale_q;

	// Captured sample
	logic [vcsp_pkg::COLUMN_W-1:0]  column_q;
	logic [vcsp_pkg::DEPTH_W-1:0]   depth_q;
	logic [vcsp_pkg::TERRAIN_W-1:0] terrain_q;
	logic [vcsp_pkg::COLOR_W-1:0]   color_q;
	logic                           first_q;

	// Arithmetic
	logic signed [vcsp_pkg::PROD_A_W-1:0] prod_a_q;
	logic signed [vcsp_pkg::PROD_B_W-1:0] prod_b_q;
	logic signed [vcsp_pkg::HOR_W-1:0]    diff;
	logic signed [vcsp_pkg::NUM_W-1:0]    num;
	logic                                 neg_q;
	logic [vcsp_pkg::QUO_W-1:0]           quo_q;
	logic [vcsp_pkg::DEN_W-1:0]           den_q;
	logic [vcsp_pkg::DEN_W-1:0]           rem_q;
	logic [vcsp_pkg::DEN_W:0]             trial;
	logic                                 fits;

	// Column state and judgment
	logic [vcsp_pkg::TOP_W-1:0] top_q;
	logic [vcsp_pkg::TOP_W-1:0] top_eff;
	logic [vcsp_pkg::QUO_W-1:0] proj;
	logic                       hit;
	logic                       out_valid_q;

	assign diff = $signed({2'b00, cam_q}) - $signed({4'b0000, terrain_q});
	assign num  = $signed({{2{prod_a_q[vcsp_pkg::PROD_A_W-1]}}, prod_a_q, 1'b0})
	            + $signed({prod_b_q[vcsp_pkg::PROD_B_W-1], prod_b_q});

	assign trial = {rem_q, quo_q[vcsp_pkg::QUO_W-1]};
	assign fits  = (trial >= {1'b0, den_q});

	// A negative numerator truncates to zero or below: clip to row 0
	assign top_eff = first_q ? ROWS_INIT : top_q;
	assign proj    = neg_q ? '0 : quo_q;
	assign hit     = (proj < vcsp_pkg::QUO_W'(top_eff));

	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_q   <= vcsp_pkg::CAM_RESET;
			hor_q   <= vcsp_pkg::HOR_RESET;
			scale_q <= vcsp_pkg::SCALE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				vcsp_pkg::CFG_CAMERA_HEIGHT:    cam_q   <= cfg_data[vcsp_pkg::CAM_W-1:0];
				vcsp_pkg::CFG_HORIZON_HALF:     hor_q   <= cfg_data[vcsp_pkg::HOR_W-1:0];
				vcsp_pkg::CFG_PROJECTION_SCALE: scale_q <= cfg_data[vcsp_pkg::SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q       <= ROWS_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
				top_q       <= hit ? proj[vcsp_pkg::TOP_W-1:0] : top_eff;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers, no reset
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			column_q  <= column;
			depth_q   <= (depth == '0) ? vcsp_pkg::DEPTH_W'(1) : depth;
			terrain_q <= terrain_height;
			color_q   <= texel_color;
			first_q   <= first_in_column;
		end
		if (cmd.mul) begin
			prod_a_q <= vcsp_pkg::PROD_A_W'(diff * $signed({1'b0, scale_q}));
			prod_b_q <= vcsp_pkg::PROD_B_W'(hor_q * $signed({1'b0, depth_q}));
		end
		if (cmd.sum) begin
			neg_q <= num[vcsp_pkg::NUM_W-1];
			quo_q <= num[vcsp_pkg::QUO_W-1:0];
			den_q <= {depth_q, 1'b0};
			rem_q <= '0;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[vcsp_pkg::QUO_W-2:0], fits};
			rem_q <= fits ? vcsp_pkg::DEN_W'(trial - {1'b0, den_q})
			              : trial[vcsp_pkg::DEN_W-1:0];
		end
		if (cmd.finish) begin
			draw        <= hit;
			span_column <= hit ? column_q : '0;
			span_top    <= hit ? proj[vcsp_pkg::ROW_W-1:0] : '0;
			span_bottom <= hit ? vcsp_pkg::ROW_W'(top_eff - 1'b1) : '0;
			span_color  <= hit ? color_q : '0;
		end
	end

	a_top_range: assert property (@(posedge clk) disable iff (!arst_n)
		top_q <= ROWS_INIT)
		else $error("topmost row beyond screen height");

	a_finish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid_q)
		else $error("finished sample not presented");

	a_no_draw_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !draw) |-> (span_column == '0) && (span_top == '0)
			&& (span_bottom == '0) && (span_color == '0))
		else $error("span fields not cleared without draw");

endmodule

/* hdl/voxel_column_span_projector.sv */
// ----------------------------------------------------------------------------
// voxel_column_span_projector: per-column span projector of a voxel terrain
// Projects one depth sample of a column ray to a screen row and emits the
// vertical span that becomes visible above the topmost row drawn so far.
// ----------------------------------------------------------------------------
// Samples are handled one at a time: an accepted input beat passes through
// capture, multiply, sum, the 23-step restoring divider (one quotient bit a
//   cycle) and finish before its result beat shows; finish waits while the
//   previous result beat is still held in the output register.
// A new input beat is taken while the previous result beat still waits.
// Reset (arst_n low) clears the sequencer, empties the output register, sets
//   the topmost row to SCREEN_ROWS and the configuration registers to their defaults.
module voxel_column_span_projector #(
	parameter int SCREEN_ROWS = 240
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration write port
	input  logic                                cfg_we,
	input  logic [vcsp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [vcsp_pkg::CFG_DATA_W-1:0]     cfg_data,
	// Sample stream
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// tdata from bit 0: column[8:0], depth[18:9], terrain_height[26:19],
	//   texel_color[42:27], zero fill[47:43]
	input  logic [vcsp_pkg::S_TDATA_W-1:0]      s_axis_tdata,
	// tuser: first_in_column
	input  logic                                s_axis_tuser,
	// Span stream
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// tdata from bit 0: span_column[8:0], span_top[16:9], span_bottom[24:17],
	//   span_color[40:25], zero fill[47:41]
	output logic [vcsp_pkg::M_TDATA_W-1:0]      m_axis_tdata,
	// tuser: draw
	output logic                                m_axis_tuser
);

	vcsp_pkg::cmd_t cmd;
	vcsp_pkg::sts_t sts;

	logic [vcsp_pkg::COLUMN_W-1:0] span_column;
	logic [vcsp_pkg::ROW_W-1:0]    span_top;
	logic [vcsp_pkg::ROW_W-1:0]    span_bottom;
	logic [vcsp_pkg::COLOR_W-1:0]  span_color;

	// Sequence one sample at a time; the input side opens only when idle
	vcsp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Unpack the sample beat straight into the datapath capture registers
	vcsp_dpath #(
		.SCREEN_ROWS (SCREEN_ROWS)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.column          (s_axis_tdata[8:0]),
		.depth           (s_axis_tdata[18:9]),
		.terrain_height  (s_axis_tdata[26:19]),
		.texel_color     (s_axis_tdata[42:27]),
		.first_in_column (s_axis_tuser),
		.cmd             (cmd),
		.sts             (sts),
		.out_valid       (m_axis_tvalid),
		.out_ready       (m_axis_tready),
		.draw            (m_axis_tuser),
		.span_column     (span_column),
		.span_top        (span_top),
		.span_bottom     (span_bottom),
		.span_color      (span_color)
	);

	// Pack the span beat, zero fill to whole bytes
	assign m_axis_tdata = {7'b0, span_color, span_bottom, span_top, span_column};

endmodule
